/* rtl/xpr_pkg.sv */
// package for the x87 partial remainder block
// holds shared types and constants; no dependencies
package xpr_pkg;

    localparam logic [14:0] EXP_MAX = 15'h7fff;
    localparam int PARTIAL_BITS = 63;
    localparam int FULL_LIMIT = 64;

    // classified job handed from front to back
    typedef struct packed {
        logic        reject;
        logic        pass;
        logic        nearest;
        logic        partial;
        logic [6:0]  shift;
        logic [15:0] base;
        logic        sign;
        logic        neg_case;
        logic        neg1;      // dividend exponent exactly one below divisor
        logic [63:0] xs;
        logic [15:0] xse;
        logic [63:0] ys;
    } t_job;

    typedef struct packed {
        logic        rejected;
        logic [63:0] sig;
        logic [15:0] se;
        logic        c0;
        logic        c1;
        logic        c2;
        logic        c3;
    } t_res;

    localparam int JOB_W = $bits(t_job);
    localparam int RES_W = $bits(t_res);

endpackage

/* rtl/xpr_ram.sv */
// generic single-port-write, registered-read ram
// no dependencies
module xpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/xpr_front.sv */
// front end: operand checks and classification of one word
// depends on xpr_pkg
module xpr_front (
    input  logic [0:0]           i_req_type,
    input  logic [63:0]          i_xs,
    input  logic [15:0]          i_xse,
    input  logic [63:0]          i_ys,
    input  logic [15:0]          i_yse,
    output xpr_pkg::t_job        o_job
);
    logic [14:0] xe, ye;
    logic        bad_x, bad_y;
    logic [16:0] diff;

    function automatic logic bad_op(input logic [63:0] s, input logic [14:0] e);
        logic ib;
        ib = s[63];
        bad_op = ((e == 15'd0) && (s != 64'd0)) || ((e != 15'd0) && !ib) ||
                 ((e == xpr_pkg::EXP_MAX) && (s != {1'b1, 63'd0}));
    endfunction

    always_comb begin
        xe = i_xse[14:0];
        ye = i_yse[14:0];
        bad_x = bad_op(i_xs, xe);
        bad_y = bad_op(i_ys, ye);
        diff = {2'b00, xe} - {2'b00, ye};
        o_job = '0;
        o_job.xs = i_xs;
        o_job.xse = i_xse;
        o_job.ys = i_ys;
        o_job.nearest = i_req_type[0];
        o_job.sign = i_xse[15];
        o_job.reject = bad_x || bad_y || (xe == xpr_pkg::EXP_MAX) ||
                       ((ye == 15'd0) && (i_ys == 64'd0));
        o_job.pass = ((xe == 15'd0) && (i_xs == 64'd0)) || (ye == xpr_pkg::EXP_MAX);
        if (diff[16]) begin
            // dividend below divisor
            o_job.neg_case = 1'b1;
            o_job.neg1 = (diff == 17'h1ffff);
            o_job.base = {1'b0, xe};
        end else if (diff[15:0] >= 16'(xpr_pkg::FULL_LIMIT)) begin
            o_job.partial = 1'b1;
            o_job.shift = 7'(xpr_pkg::PARTIAL_BITS);
            o_job.base = {1'b0, xe} - 16'(xpr_pkg::PARTIAL_BITS);
        end else begin
            o_job.shift = diff[6:0];
            o_job.base = {1'b0, ye};
        end
    end
endmodule

/* rtl/xpr_back.sv */
// back end: shift-subtract divider, rounding and normalize sequencer
// depends on xpr_pkg
module xpr_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_job_valid,
    output logic                 o_job_ready,
    input  xpr_pkg::t_job        i_job,
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output xpr_pkg::t_res        o_res
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_RND  = 5'b00100,
        S_NORM = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state        r_state, n_state;
    xpr_pkg::t_job r_job;
    logic [127:0]  r_num;
    logic [63:0]   r_rem;
    logic [2:0]    r_q;
    logic [6:0]    r_cnt;
    logic [15:0]   r_exp;
    logic          r_sign;
    xpr_pkg::t_res r_res;

    logic [63:0]   sub_r;
    logic          sub_take;
    logic [64:0]   sh_r;
    logic [63:0]   other;
    logic          qc0, qc1, qc3;

    assign o_job_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_OUT);
    assign o_res = r_res;

    always_comb begin
        sh_r = {r_rem, r_num[127]};
        sub_take = sh_r[64] || (sh_r[63:0] >= r_job.ys);
        sub_r = sub_take ? (sh_r[63:0] - r_job.ys) : sh_r[63:0];
        other = r_job.ys - r_rem;
        // quotient bits only reported for a complete reduction
        qc0 = !r_job.partial && r_q[2];
        qc3 = !r_job.partial && r_q[1];
        qc1 = !r_job.partial && r_q[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_job_valid) n_state = S_DIV;
            S_DIV: begin
                if (r_job.reject || r_job.pass) n_state = S_OUT;
                else if (r_job.neg_case) n_state = S_NORM;
                else if (r_cnt == 7'd0) n_state = S_RND;
            end
            S_RND:  n_state = S_NORM;
            S_NORM: if (r_rem == 64'd0 || r_rem[63] || r_exp[15] || r_exp == 16'd0)
                        n_state = S_OUT;
            S_OUT:  if (i_res_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_job <= i_job;
                r_num <= {64'd0, i_job.xs} << i_job.shift;
                r_rem <= '0;
                r_q <= '0;
                r_cnt <= 7'd127;
                r_exp <= i_job.base;
                r_sign <= i_job.sign;
            end
            S_DIV: begin
                if (r_job.reject) begin
                    r_res <= '{1'b1, 64'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0};
                end else if (r_job.pass) begin
                    r_res <= '{1'b0, r_job.xs, r_job.xse, 1'b0, 1'b0, 1'b0, 1'b0};
                end else if (r_job.neg_case) begin
                    // fprem1 with dividend one binade below and larger significand
                    if (r_job.nearest && r_job.neg1 && (r_job.xs > r_job.ys)) begin
                        r_q <= 3'd1;
                        r_rem <= r_job.ys - (r_job.xs - r_job.ys);
                        r_sign <= ~r_job.sign;
                    end else begin
                        r_rem <= r_job.xs;
                    end
                end else begin
                    r_rem <= sub_r;
                    r_q <= {r_q[1:0], sub_take};
                    r_num <= {r_num[126:0], 1'b0};
                    r_cnt <= r_cnt - 7'd1;
                end
            end
            S_RND: begin
                if (!r_job.partial && r_job.nearest &&
                    ((r_rem > other) || (r_rem == other && r_q[0]))) begin
                    r_q <= r_q + 3'd1;
                    r_rem <= other;
                    r_sign <= ~r_sign;
                end
            end
            S_NORM: begin
                if (r_rem == 64'd0) begin
                    r_res <= '{1'b0, 64'd0, {r_sign, 15'd0}, qc0, qc1, r_job.partial, qc3};
                end else if (r_exp[15] || r_exp == 16'd0) begin
                    r_res <= '{1'b1, 64'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0};
                end else if (r_rem[63]) begin
                    r_res <= '{1'b0, r_rem, {r_sign, r_exp[14:0]}, qc0, qc1,
                               r_job.partial, qc3};
                end else begin
                    r_rem <= {r_rem[62:0], 1'b0};
                    r_exp <= r_exp - 16'd1;
                end
            end
            S_OUT: ;
            default: ;
        endcase
    end

`ifndef ASSERT_OFF
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_ready |-> !o_res_valid) else $error("ready while result pending");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_res))
        else $error("result changed while stalled");
    a_rej_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.rejected |-> o_res.sig == 64'd0 && !o_res.c2)
        else $error("rejected result not cleared");
`endif
endmodule

/* rtl/x87_partial_remainder.sv */
// top level of the x87 partial remainder (fprem / fprem1) block
// depends on xpr_pkg, xpr_front, xpr_ram, xpr_back
// reject or pass-through go to output directly; dividend below divisor to normalize;
//   else 128-step shift-subtract divide, rounding, then normalize one bit per shift
// throughput: one word at a time in the back end; a 4-deep queue sits in front
// reset: i_rst_n synchronous active low clears queue pointers and the sequencer
module x87_partial_remainder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // tdata: dividend_significand, dividend_sign_exponent,
    //        divisor_significand, divisor_sign_exponent
    input  logic [159:0]  s_axis_tdata,
    // tuser: req_type
    input  logic [0:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // tdata: rejected, remainder_significand, remainder_sign_exponent,
    //        cond_c0, cond_c1, cond_c2, cond_c3, zero fill
    output logic [87:0]   m_axis_tdata
);
    localparam int AW = $clog2(QUEUE_DEPTH);

    xpr_pkg::t_job front_job, q_job;
    logic [AW:0]   r_wp, r_rp;
    logic          q_full, q_empty, pop, back_ready;
    logic          r_rd_valid;
    xpr_pkg::t_res res;

    // classify the incoming word
    xpr_front u_front (
        .i_req_type (s_axis_tuser),
        .i_xs       (s_axis_tdata[63:0]),
        .i_xse      (s_axis_tdata[79:64]),
        .i_ys       (s_axis_tdata[143:80]),
        .i_yse      (s_axis_tdata[159:144]),
        .o_job      (front_job)
    );

    assign q_full = (r_wp[AW] != r_rp[AW]) && (r_wp[AW-1:0] == r_rp[AW-1:0]);
    assign q_empty = (r_wp == r_rp);
    assign s_axis_tready = !q_full;

    // one-word read staging: pop when back is free and nothing staged
    assign pop = !q_empty && !r_rd_valid && back_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) r_wp <= r_wp + {{AW{1'b0}}, 1'b1};
            if (pop) r_rp <= r_rp + {{AW{1'b0}}, 1'b1};
            r_rd_valid <= pop;
        end
    end

    xpr_ram #(.WIDTH(xpr_pkg::JOB_W), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_we    (s_axis_tvalid && s_axis_tready),
        .i_waddr (r_wp[AW-1:0]),
        .i_wdata (front_job),
        .i_raddr (r_rp[AW-1:0]),
        .o_rdata (q_job)
    );

    xpr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (r_rd_valid),
        .o_job_ready (back_ready),
        .i_job       (q_job),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (res)
    );

    assign m_axis_tdata = {3'd0, res.c3, res.c2, res.c1, res.c0, res.se, res.sig, res.rejected};

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !(s_axis_tvalid && s_axis_tready)) else $error("queue overflow");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_empty) else $error("pop from empty queue");
    a_stage_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_valid |-> back_ready) else $error("staged word lost");
`endif
endmodule

/* sim/xpr_checker.sv */
// checker for the x87 partial remainder block: predicts each result word
// from accepted input words and compares; depends on xpr_pkg for types and constants
module xpr_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic         i_in_ready,
    input  logic [159:0] i_in_data,
    input  logic [0:0]   i_in_user,
    input  logic         i_out_valid,
    input  logic         i_out_ready,
    input  logic [87:0]  i_out_data,
    output int           o_errors,
    output int           o_pending,
    output int           o_checked
);
    xpr_pkg::t_res remainder_q[$];
    int            err_cnt = 0;
    int            chk_cnt = 0;

    function automatic int count_lead(logic [63:0] x);
        int n;
        n = 0;
        while (n < 64 && !x[63]) begin
            x = x << 1;
            n++;
        end
        return n;
    endfunction

    function automatic logic operand_bad(logic [63:0] sig, logic [14:0] e);
        if (e == 0 && sig[63]) return 1'b1;
        if (e != 0 && !sig[63]) return 1'b1;
        if (e == 0 && sig != 0) return 1'b1;
        if (e == xpr_pkg::EXP_MAX && sig != 64'h8000000000000000) return 1'b1;
        return 1'b0;
    endfunction

    // normalize magnitude; returns 0 when the result would be subnormal
    function automatic logic normalize(output xpr_pkg::t_res r, input logic sgn,
                                       input logic [63:0] mag, input int base);
        int s;
        int e;
        r = '0;
        if (mag == 0) begin
            r.se = {sgn, 15'd0};
            return 1'b1;
        end
        s = count_lead(mag);
        e = base - s;
        if (e < 1) return 1'b0;
        r.sig = mag << s;
        r.se = {sgn, e[14:0]};
        return 1'b1;
    endfunction

    function automatic xpr_pkg::t_res predict_remainder(logic nearest, logic [63:0] xs,
                                                        logic [15:0] xse, logic [63:0] ys,
                                                        logic [15:0] yse);
        xpr_pkg::t_res r;
        xpr_pkg::t_res p;
        logic [14:0] xe;
        logic [14:0] ye;
        int diff;
        int shift;
        int base;
        logic partial;
        logic [127:0] num;
        logic [63:0] rem;
        logic [63:0] other;
        logic carry;
        logic [2:0] q;
        logic sgn;
        logic ok;
        r = '0;
        xe = xse[14:0];
        ye = yse[14:0];
        q = 0;
        if (operand_bad(xs, xe) || operand_bad(ys, ye) || xe == xpr_pkg::EXP_MAX ||
            (ye == 0 && ys == 0)) begin
            r.rejected = 1'b1;
            return r;
        end
        if ((xe == 0 && xs == 0) || ye == xpr_pkg::EXP_MAX) begin
            r.sig = xs;
            r.se = xse;
            return r;
        end
        diff = int'(xe) - int'(ye);
        p = '0;
        if (diff < 0) begin
            if (nearest && diff == -1 && xs > ys) begin
                q = 1;
                ok = normalize(p, ~xse[15], ys - (xs - ys), int'(xe));
            end else begin
                p.sig = xs;
                p.se = xse;
                ok = 1'b1;
            end
        end else begin
            partial = diff >= xpr_pkg::FULL_LIMIT;
            shift = partial ? xpr_pkg::PARTIAL_BITS : diff;
            base = partial ? int'(xe) - xpr_pkg::PARTIAL_BITS : int'(ye);
            num = {64'd0, xs} << shift;
            rem = 0;
            sgn = xse[15];
            // one-bit restoring division over the whole shifted dividend
            for (int i = 127; i >= 0; i--) begin
                carry = rem[63];
                rem = {rem[62:0], num[i]};
                q = {q[1:0], 1'b0};
                if (carry || rem >= ys) begin
                    rem = rem - ys;
                    q[0] = 1'b1;
                end
            end
            if (!partial && nearest) begin
                other = ys - rem;
                if (rem > other || (rem == other && q[0])) begin
                    q = q + 1;
                    rem = other;
                    sgn = ~sgn;
                end
            end
            ok = normalize(p, sgn, rem, base);
            if (partial) begin
                q = 0;
                p.c2 = 1'b1;
            end
        end
        if (!ok) begin
            r.rejected = 1'b1;
            return r;
        end
        r.sig = p.sig;
        r.se = p.se;
        r.c2 = p.c2;
        r.c0 = q[2];
        r.c1 = q[0];
        r.c3 = q[1];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %0s: got %h expected %h at %0t", what, got, want, $time);
        err_cnt++;
    endtask

    assign o_pending = remainder_q.size();
    assign o_errors = err_cnt;
    assign o_checked = chk_cnt;

    always @(posedge i_clk) begin
        xpr_pkg::t_res want;
        xpr_pkg::t_res got;
        if (i_rst_n && i_in_valid && i_in_ready)
            remainder_q.push_back(predict_remainder(i_in_user[0], i_in_data[63:0],
                i_in_data[79:64], i_in_data[143:80], i_in_data[159:144]));
        if (i_rst_n && i_out_valid && i_out_ready) begin
            got.rejected = i_out_data[0];
            got.sig = i_out_data[64:1];
            got.se = i_out_data[80:65];
            got.c0 = i_out_data[81];
            got.c1 = i_out_data[82];
            got.c2 = i_out_data[83];
            got.c3 = i_out_data[84];
            chk_cnt++;
            if (remainder_q.size() == 0) begin
                report_mismatch("unexpected word", i_out_data[64:1], 64'd0);
            end else begin
                want = remainder_q.pop_front();
                if (got.rejected != want.rejected)
                    report_mismatch("rejected", 64'(got.rejected), 64'(want.rejected));
                if (got.sig != want.sig) report_mismatch("significand", got.sig, want.sig);
                if (got.se != want.se)
                    report_mismatch("sign/exponent", 64'(got.se), 64'(want.se));
                if (got.c0 != want.c0) report_mismatch("c0", 64'(got.c0), 64'(want.c0));
                if (got.c1 != want.c1) report_mismatch("c1", 64'(got.c1), 64'(want.c1));
                if (got.c2 != want.c2) report_mismatch("c2", 64'(got.c2), 64'(want.c2));
                if (got.c3 != want.c3) report_mismatch("c3", 64'(got.c3), 64'(want.c3));
            end
        end
    end
endmodule

/* sim/testbench.sv */
// testbench top for the x87 partial remainder block
// drives operand words with random gaps and back-pressure; checks via xpr_checker
module testbench;
    localparam int RANDOM_WORDS = 930;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [159:0] s_axis_tdata;
    logic [0:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [87:0]  m_axis_tdata;

    int  errors;
    int  pending;
    int  checked;
    int  sent;
    // long receiver hold-off request, handled once by the sink process
    logic hold_req;
    logic sink_quiet;

    x87_partial_remainder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    xpr_checker chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // random 64-bit value
    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // normal significand: integer bit set
    function automatic logic [63:0] norm_sig();
        logic [63:0] s;
        s = rand64();
        s[63] = 1'b1;
        // sometimes sparse patterns to hit exact and tie cases
        if ($urandom_range(0, 5) == 0) s = 64'h8000000000000000 | (s & 64'hff00000000000000);
        return s;
    endfunction

    // send one word, waiting the drawn gap, holding until accepted
    // valid stays high after acceptance so back-to-back words need no gap
    task automatic send_word(logic nearest, logic [63:0] xs, logic [15:0] xse,
                             logic [63:0] ys, logic [15:0] yse, logic gap_on);
        int gap;
        gap = gap_on ? $urandom_range(0, 19) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {yse, ys, xse, xs};
        s_axis_tuser <= nearest;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent++;
        @(negedge i_clk);
    endtask

    // drop valid after the last word of a burst
    task automatic idle_bus();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
    endtask

    // random operand pair, mostly well-formed with varied exponent spread
    task automatic send_random(logic gap_on);
        logic [63:0] xs;
        logic [63:0] ys;
        logic [15:0] xse;
        logic [15:0] yse;
        int kind;
        int ye;
        int d;
        kind = $urandom_range(0, 99);
        xs = norm_sig();
        ys = norm_sig();
        ye = $urandom_range(1, 32766);
        if (kind < 40) d = $urandom_range(0, 63) - 2;
        else if (kind < 55) d = $urandom_range(0, 3) - 1;
        else if (kind < 70) d = $urandom_range(60, 200);
        else if (kind < 80) begin
            // small exponents so results can become subnormal
            ye = $urandom_range(1, 70);
            d = $urandom_range(0, 63) - 1;
        end else d = $urandom_range(0, 32766) - ye;
        d = d + ye;
        if (d < 1) d = 1;
        if (d > 32766) d = 32766;
        xse = {1'($urandom()), 15'(d)};
        yse = {1'($urandom()), 15'(ye)};
        if (kind >= 90) begin
            // raw noise, including zeros, infinities, nans and bad encodings
            xs = rand64();
            ys = rand64();
            xse = 16'($urandom());
            yse = 16'($urandom());
        end
        if (kind >= 40 && kind < 55) ys = xs ^ (64'(1) << $urandom_range(0, 62));
        send_word(1'($urandom()), xs, xse, ys, yse, gap_on);
    endtask

    localparam logic [63:0] ONE = 64'h8000000000000000;

    // sink: random stalls, plus one long hold-off on request
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        sink_quiet = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req && !sink_quiet) begin
                m_axis_tready <= 1'b0;
                repeat (2000) @(negedge i_clk);
                sink_quiet = 1'b1;
            end
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    // stimulus and verdict
    initial begin
        logic gaps;
        int wait_cycles;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        hold_req = 1'b0;
        sent = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes and each special case, both modes
        for (int m = 0; m < 2; m++) begin
            // zero dividend and infinite divisor pass through
            send_word(1'(m), 64'd0, 16'h8000, ONE, 16'h3fff, 1'b1);
            send_word(1'(m), ONE | 64'h5, 16'h4005, ONE, 16'hffff, 1'b1);
            // zero divisor, infinite dividend, nan, unnormal, subnormal
            send_word(1'(m), ONE, 16'h3fff, 64'd0, 16'h0000, 1'b1);
            send_word(1'(m), ONE, 16'h7fff, ONE, 16'h3fff, 1'b1);
            send_word(1'(m), 64'hc000000000000000, 16'h3fff, 64'hc000000000000000, 16'h7fff,
                      1'b1);
            send_word(1'(m), 64'h4000000000000000, 16'h3fff, ONE, 16'h3fff, 1'b1);
            send_word(1'(m), 64'h0000000000000001, 16'h0000, ONE, 16'h3fff, 1'b1);
            send_word(1'(m), ONE, 16'h0000, ONE, 16'h3fff, 1'b1);
            // exact halves and ties, one below divisor exponent, partial reductions
            send_word(1'(m), 64'hc000000000000000, 16'h4000, ONE, 16'h3fff, 1'b1);
            send_word(1'(m), 64'hffffffffffffffff, 16'h3ffe, ONE, 16'h3fff, 1'b1);
            send_word(1'(m), 64'hffffffffffffffff, 16'h7ffe, ONE, 16'h0001, 1'b1);
            send_word(1'(m), ONE, 16'h403f, 64'hffffffffffffffff, 16'h3fff, 1'b1);
            // subnormal result
            send_word(1'(m), 64'hffffffffffffffff, 16'h0002, ONE, 16'h0001, 1'b1);
        end

        // pause until drained
        idle_bus();
        while (pending != 0) @(negedge i_clk);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            gaps = !((n / 100) % 3 == 1);
            if (n == 300) hold_req = 1'b1;
            if (hold_req && sink_quiet) hold_req = 1'b0;
            if (n == 600) begin
                idle_bus();
                while (pending != 0) @(negedge i_clk);
            end
            send_random(gaps);
        end
        idle_bus();

        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 200000) begin
            @(negedge i_clk);
            wait_cycles++;
        end
        repeat (250) @(negedge i_clk);
        $display("covered %0d operand words in both modes, %0d results checked", sent, checked);
        $display("included rejects, pass-through, partial and exact remainders, stalls");
        if (errors == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // run limit
    initial begin
        #4000000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule

/* filelist.f */
rtl/xpr_pkg.sv
rtl/xpr_ram.sv
rtl/xpr_front.sv
rtl/xpr_back.sv
rtl/x87_partial_remainder.sv
sim/xpr_checker.sv
sim/testbench.sv
